>>> sv/sxlp_pkg.sv
// sxlp_pkg: types, codes and field-length decoders for the 6LoWPAN IPHC header parser
// no dependencies; used by the interfaces and by sixlowpan_iphc_header_parser
package sxlp_pkg;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_DISPATCH = 3'd1,
    ST_RSV_DST      = 3'd2,
    ST_BAD_NHC      = 3'd3,
    ST_LATER_FRAG   = 3'd4,
    ST_TRUNCATED    = 3'd5
  } status_t;

  // parser phase
  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_DISP_TOP = 4'd1,
    PH_FRAG     = 4'd2,
    PH_DISP_IN  = 4'd3,
    PH_IPHC2    = 4'd4,
    PH_PRE      = 4'd5,
    PH_NHB      = 4'd6,
    PH_ADDR     = 4'd7,
    PH_NHCD     = 4'd8,
    PH_NHCB     = 4'd9,
    PH_UDP      = 4'd10
  } phase_t;

  // one result word
  typedef struct packed {
    status_t     status;
    logic [5:0]  header_len;
    logic [7:0]  next_proto;
    logic [15:0] udp_sport;
    logic [15:0] udp_dport;
    logic        ports_valid;
  } res_word_t;

  // destination address length, or the reserved flag
  typedef struct packed {
    logic       rsv;
    logic [4:0] len;
  } dst_info_t;

  localparam logic [5:0]  MAX_POS       = 6'd63;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;
  localparam logic [15:0] NHC_PORT_4BIT = 16'hf0b0;
  localparam logic [15:0] NHC_PORT_8BIT = 16'hf000;
  localparam logic [4:0]  DISP_FRAG1    = 5'b11000;
  localparam logic [4:0]  DISP_FRAGN    = 5'b11100;
  localparam logic [2:0]  DISP_IPHC     = 3'b011;
  localparam logic [4:0]  DISP_NHC_UDP  = 5'b11110;
  localparam logic [2:0]  FRAG_REST     = 3'd3;
  localparam logic [5:0]  UDP_HDR_LEN   = 6'd8;

  // inline traffic class / flow label bytes from the TF field
  function automatic logic [2:0] tf_len(input logic [7:0] first_byte);
    logic [2:0] r;
    begin
      case (first_byte[4:3])
        2'd0:    r = 3'd4;
        2'd1:    r = 3'd3;
        2'd2:    r = 3'd1;
        default: r = 3'd0;
      endcase
      return r;
    end
  endfunction

  // inline source address bytes
  function automatic logic [4:0] src_len(input logic [7:0] sec);
    logic [4:0] r;
    begin
      if (!sec[6] && sec[5:4] == 2'd0) r = 5'd16;
      else if (sec[5:4] == 2'd1)       r = 5'd8;
      else if (sec[5:4] == 2'd2)       r = 5'd2;
      else                             r = 5'd0;
      return r;
    end
  endfunction

  // inline destination address bytes, multicast modes included
  function automatic dst_info_t dst_len(input logic [7:0] sec);
    dst_info_t r;
    begin
      r.rsv = 1'b0;
      r.len = 5'd0;
      if (!sec[2] && sec[1:0] == 2'd0) begin
        r.len = 5'd16;
      end else if (sec[3]) begin
        if (sec[2]) begin
          if (sec[1:0] == 2'd0) r.len = 5'd6;
          else                  r.rsv = 1'b1;
        end else begin
          case (sec[1:0])
            2'd1:    r.len = 5'd6;
            2'd2:    r.len = 5'd4;
            default: r.len = 5'd1;
          endcase
        end
      end else begin
        case (sec[1:0])
          2'd0:    r.rsv = 1'b1;
          2'd1:    r.len = 5'd8;
          2'd2:    r.len = 5'd2;
          default: r.len = 5'd0;
        endcase
      end
      return r;
    end
  endfunction

  // NHC-UDP bytes after the dispatch: ports plus optional checksum
  function automatic logic [2:0] nhc_len(input logic [7:0] d);
    logic [2:0] r;
    begin
      case (d[1:0])
        2'd0:    r = 3'd4;
        2'd1:    r = 3'd3;
        2'd2:    r = 3'd3;
        default: r = 3'd1;
      endcase
      if (!d[2]) r = r + 3'd2;
      return r;
    end
  endfunction

endpackage

>>> sv/sxlp_ifs.sv
// sxlp_ifs: valid/ready channel interfaces for frame bytes and parse results
// depends on sxlp_pkg
interface sxlp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       first;
  logic       last;

  modport source (output valid, frame_byte, first, last, input ready);
  modport sink (input valid, frame_byte, first, last, output ready);
endinterface

interface sxlp_result_if;
  logic              valid;
  logic              ready;
  sxlp_pkg::status_t status;
  logic [5:0]        header_len;
  logic [7:0]        next_proto;
  logic [15:0]       udp_sport;
  logic [15:0]       udp_dport;
  logic              ports_valid;

  modport source (output valid, status, header_len, next_proto, udp_sport, udp_dport,
                  ports_valid, input ready);
  modport sink (input valid, status, header_len, next_proto, udp_sport, udp_dport,
                ports_valid, output ready);
endinterface

>>> sv/sixlowpan_iphc_header_parser.sv
// sixlowpan_iphc_header_parser: one frame byte per cycle, at most one result word
// per frame; the result word is registered from the byte that decides the outcome
// throughput: one byte per cycle unless stalled; parser state plus
// one output and one skid register; input stalls only while the skid holds a word
// reset: synchronous rst clears parser state and both output valids; no clearing pass
// depends on sxlp_pkg, sxlp_byte_if, sxlp_result_if
module sixlowpan_iphc_header_parser (
  input logic           clk,
  input logic           rst,
  sxlp_byte_if.sink     frame,
  sxlp_result_if.source result
);
  import sxlp_pkg::*;

  // parser state
  logic [5:0]  byte_pos, byte_pos_next;
  logic [2:0]  frag_skip, frag_skip_next;
  logic [7:0]  iphc_first, iphc_first_next;
  logic [7:0]  iphc_second, iphc_second_next;
  logic [5:0]  field_end, field_end_next;
  phase_t      phase, phase_next;
  logic [7:0]  proto_hold, proto_hold_next;
  logic [7:0]  nhc_dispatch, nhc_dispatch_next;
  logic [15:0] sport_acc, sport_acc_next;
  logic [15:0] dport_acc, dport_acc_next;
  logic        reported, reported_next;

  // step temporaries
  phase_t      cur_phase;
  logic        go_nh, go_addr, go_tail;
  logic        res_v, res_ok, res_ports;
  status_t     res_status;
  dst_info_t   dl;
  dst_info_t   dl_addr;
  logic [2:0]  pre_n;
  logic [5:0]  addr_n;
  logic [5:0]  seg_len, seg_start, cur_pos, idx;
  res_word_t   res_word;

  // output register and skid register
  logic        out_valid, skid_valid;
  res_word_t   out_word, skid_word;
  logic        in_fire, out_fire;

  assign frame.ready = !skid_valid;
  assign in_fire     = frame.valid && frame.ready;
  assign out_fire    = out_valid && result.ready;

  // one parse step for the byte on the input
  always_comb begin
    byte_pos_next     = byte_pos;
    frag_skip_next    = frag_skip;
    iphc_first_next   = iphc_first;
    iphc_second_next  = iphc_second;
    field_end_next    = field_end;
    phase_next        = phase;
    proto_hold_next   = proto_hold;
    nhc_dispatch_next = nhc_dispatch;
    sport_acc_next    = sport_acc;
    dport_acc_next    = dport_acc;
    reported_next     = reported;
    go_nh      = 1'b0;
    go_addr    = 1'b0;
    go_tail    = 1'b0;
    res_v      = 1'b0;
    res_ok     = 1'b0;
    res_ports  = 1'b0;
    res_status = ST_OK;
    dl         = dst_len(frame.frame_byte);
    dl_addr    = '0;
    pre_n      = '0;
    addr_n     = '0;
    seg_len    = '0;
    seg_start  = '0;
    cur_pos    = '0;
    idx        = '0;

    // a first mark always opens a new frame
    if (frame.first) begin
      byte_pos_next     = '0;
      frag_skip_next    = '0;
      iphc_first_next   = '0;
      iphc_second_next  = '0;
      field_end_next    = '0;
      proto_hold_next   = '0;
      nhc_dispatch_next = '0;
      sport_acc_next    = '0;
      dport_acc_next    = '0;
      reported_next     = 1'b0;
      phase_next        = PH_DISP_TOP;
    end
    cur_phase = phase_next;

    if (cur_phase != PH_IDLE) begin
      if (byte_pos_next < MAX_POS) byte_pos_next = byte_pos_next + 6'd1;
      cur_pos = byte_pos_next - 6'd1;

      case (cur_phase)
        PH_DISP_TOP, PH_DISP_IN: begin
          if (cur_phase == PH_DISP_TOP && frame.frame_byte[7:3] == DISP_FRAGN) begin
            res_v      = 1'b1;
            res_status = ST_LATER_FRAG;
          end else if (cur_phase == PH_DISP_TOP && frame.frame_byte[7:3] == DISP_FRAG1) begin
            frag_skip_next = FRAG_REST;
            phase_next     = PH_FRAG;
          end else if (frame.frame_byte[7:5] == DISP_IPHC) begin
            iphc_first_next = frame.frame_byte;
            phase_next      = PH_IPHC2;
          end else begin
            res_v      = 1'b1;
            res_status = ST_BAD_DISPATCH;
          end
        end
        PH_FRAG: begin
          if (frag_skip_next != 3'd0) frag_skip_next = frag_skip_next - 3'd1;
          if (frag_skip_next == 3'd0) phase_next = PH_DISP_IN;
        end
        PH_IPHC2: begin
          iphc_second_next = frame.frame_byte;
          if (dl.rsv) begin
            res_v      = 1'b1;
            res_status = ST_RSV_DST;
          end else begin
            pre_n = {2'b00, frame.frame_byte[7]} + tf_len(iphc_first_next);
            if (pre_n != 3'd0) begin
              field_end_next = byte_pos_next + {3'b000, pre_n};
              phase_next     = PH_PRE;
            end else begin
              go_nh = 1'b1;
            end
          end
        end
        PH_PRE: begin
          if (byte_pos_next >= field_end_next) go_nh = 1'b1;
        end
        PH_NHB: begin
          proto_hold_next = frame.frame_byte;
          go_addr         = 1'b1;
        end
        PH_ADDR: begin
          if (byte_pos_next >= field_end_next) go_tail = 1'b1;
        end
        PH_NHCD: begin
          if (frame.frame_byte[7:3] != DISP_NHC_UDP) begin
            res_v      = 1'b1;
            res_status = ST_BAD_NHC;
          end else begin
            nhc_dispatch_next = frame.frame_byte;
            proto_hold_next   = PROTO_UDP;
            field_end_next    = byte_pos_next + {3'b000, nhc_len(frame.frame_byte)};
            phase_next        = PH_NHCB;
          end
        end
        PH_NHCB: begin
          seg_len   = {3'b000, nhc_len(nhc_dispatch_next)};
          seg_start = (field_end_next >= seg_len) ? field_end_next - seg_len : '0;
          idx       = (cur_pos >= seg_start) ? cur_pos - seg_start : '0;
          case (nhc_dispatch_next[1:0])
            2'd0: begin
              if (idx < 6'd2) begin
                sport_acc_next = {sport_acc_next[7:0], frame.frame_byte};
              end else if (idx < 6'd4) begin
                dport_acc_next = {dport_acc_next[7:0], frame.frame_byte};
              end
            end
            2'd1: begin
              if (idx < 6'd2) begin
                sport_acc_next = {sport_acc_next[7:0], frame.frame_byte};
              end else if (idx == 6'd2) begin
                dport_acc_next = NHC_PORT_8BIT | {8'h00, frame.frame_byte};
              end
            end
            2'd2: begin
              if (idx == 6'd0) begin
                sport_acc_next = NHC_PORT_8BIT | {8'h00, frame.frame_byte};
              end else if (idx < 6'd3) begin
                dport_acc_next = {dport_acc_next[7:0], frame.frame_byte};
              end
            end
            default: begin
              if (idx == 6'd0) begin
                sport_acc_next = NHC_PORT_4BIT | {12'h000, frame.frame_byte[7:4]};
                dport_acc_next = NHC_PORT_4BIT | {12'h000, frame.frame_byte[3:0]};
              end
            end
          endcase
          if (byte_pos_next >= field_end_next) begin
            res_v     = 1'b1;
            res_ok    = 1'b1;
            res_ports = 1'b1;
          end
        end
        PH_UDP: begin
          seg_start = (field_end_next >= UDP_HDR_LEN) ? field_end_next - UDP_HDR_LEN : '0;
          idx       = (cur_pos >= seg_start) ? cur_pos - seg_start : '0;
          if (idx < 6'd2) begin
            sport_acc_next = {sport_acc_next[7:0], frame.frame_byte};
          end else if (idx < 6'd4) begin
            dport_acc_next = {dport_acc_next[7:0], frame.frame_byte};
          end
          if (byte_pos_next >= field_end_next) begin
            res_v     = 1'b1;
            res_ok    = 1'b1;
            res_ports = 1'b1;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase

      // next header byte inline, or straight on to the addresses
      if (go_nh) begin
        if (!iphc_first_next[2]) phase_next = PH_NHB;
        else                     go_addr    = 1'b1;
      end

      // hop limit byte plus source and destination address bytes
      if (go_addr) begin
        dl_addr = dst_len(iphc_second_next);
        addr_n = {5'b00000, iphc_first_next[1:0] == 2'b00}
               + {1'b0, src_len(iphc_second_next)}
               + {1'b0, dl_addr.len};
        if (addr_n != 6'd0) begin
          field_end_next = byte_pos_next + addr_n;
          phase_next     = PH_ADDR;
        end else begin
          go_tail = 1'b1;
        end
      end

      // NHC dispatch, plain UDP header, or done
      if (go_tail) begin
        if (iphc_first_next[2]) begin
          phase_next = PH_NHCD;
        end else if (proto_hold_next == PROTO_UDP) begin
          field_end_next = byte_pos_next + UDP_HDR_LEN;
          phase_next     = PH_UDP;
        end else begin
          res_v  = 1'b1;
          res_ok = 1'b1;
        end
      end

      // frame ended before the outcome was known
      if (!res_v && frame.last && phase_next != PH_IDLE && !reported_next) begin
        res_v      = 1'b1;
        res_status = ST_TRUNCATED;
      end

      if (res_v) begin
        phase_next    = PH_IDLE;
        reported_next = 1'b1;
      end
    end

    // result word, fields cleared on error
    res_word.status      = res_status;
    res_word.header_len  = res_ok ? byte_pos_next : '0;
    res_word.next_proto  = res_ok ? proto_hold_next : '0;
    res_word.udp_sport   = res_ports ? sport_acc_next : '0;
    res_word.udp_dport   = res_ports ? dport_acc_next : '0;
    res_word.ports_valid = res_ports;
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos     <= '0;
      frag_skip    <= '0;
      iphc_first   <= '0;
      iphc_second  <= '0;
      field_end    <= '0;
      phase        <= PH_IDLE;
      proto_hold   <= '0;
      nhc_dispatch <= '0;
      sport_acc    <= '0;
      dport_acc    <= '0;
      reported     <= 1'b0;
    end else if (in_fire) begin
      byte_pos     <= byte_pos_next;
      frag_skip    <= frag_skip_next;
      iphc_first   <= iphc_first_next;
      iphc_second  <= iphc_second_next;
      field_end    <= field_end_next;
      phase        <= phase_next;
      proto_hold   <= proto_hold_next;
      nhc_dispatch <= nhc_dispatch_next;
      sport_acc    <= sport_acc_next;
      dport_acc    <= dport_acc_next;
      reported     <= reported_next;
    end
  end

  // output register with skid behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (in_fire && res_v && (!out_valid || out_fire)) out_valid <= 1'b1;
      else if (out_fire)                                out_valid <= skid_valid;
      if (out_fire)                                skid_valid <= 1'b0;
      else if (in_fire && res_v && out_valid)      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_v && (!out_valid || out_fire)) out_word <= res_word;
    else if (out_fire && skid_valid)                  out_word <= skid_word;
    if (in_fire && res_v && out_valid && !out_fire) skid_word <= res_word;
  end

  assign result.valid       = out_valid;
  assign result.status      = out_word.status;
  assign result.header_len  = out_word.header_len;
  assign result.next_proto  = out_word.next_proto;
  assign result.udp_sport   = out_word.udp_sport;
  assign result.udp_dport   = out_word.udp_dport;
  assign result.ports_valid = out_word.ports_valid;

`ifndef SYNTHESIS
  // skid only fills behind a waiting output word
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held without output word");

  // error results carry no header length and no ports
  a_err_fields_clear: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.status != ST_OK) |->
      (out_word.header_len == 6'd0 && !out_word.ports_valid))
    else $error("error result with nonzero fields");

  // ports come only with UDP
  a_ports_udp: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.ports_valid) |-> (out_word.next_proto == PROTO_UDP))
    else $error("ports valid without UDP protocol");

  // a frame's result closes the parse
  a_idle_after_result: assert property (@(posedge clk) disable iff (rst)
    (in_fire && res_v) |=> (phase == PH_IDLE && reported))
    else $error("parser still open after result");
`endif

endmodule

>>> test/sixlowpan_iphc_header_parser_tb.sv
`timescale 1ns / 1ps
// sixlowpan_iphc_header_parser_tb: self-checking bench for the 6LoWPAN IPHC header parser
// feeds frames one word at a time, predicts each result word in-bench, compares field by field
// depends on sxlp_pkg, sxlp_ifs and sixlowpan_iphc_header_parser
module sixlowpan_iphc_header_parser_tb;
  import sxlp_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_WORDS = 700;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_HEAVY} rx_style_t;

  logic clk = 1'b0;
  logic rst;

  sxlp_byte_if   byte_ch ();
  sxlp_result_if res_ch ();

  sixlowpan_iphc_header_parser dut (
    .clk    (clk),
    .rst    (rst),
    .frame  (byte_ch),
    .result (res_ch)
  );

  always #1 clk = ~clk;

  // parser state as seen by the predictor
  logic [5:0]  hp_pos;
  logic [2:0]  hp_skip;
  logic [7:0]  hp_iphc0;
  logic [7:0]  hp_iphc1;
  logic [5:0]  hp_end;
  phase_t      hp_phase;
  logic [7:0]  hp_proto;
  logic [7:0]  hp_nhc;
  logic [15:0] hp_sport;
  logic [15:0] hp_dport;
  logic        hp_done;

  res_word_t predicted_results[$];
  int        fail_count = 0;
  int        bytes_sent = 0;

  // sender and receiver controls
  bit        offering = 1'b0;
  bit        sender_gaps = 1'b0;
  int        burst_left = 1;
  rx_style_t stall_style = RX_ALWAYS;
  int        hold_requests = 0;
  int        holds_served = 0;
  logic [7:0] frame_buf[$];

  // inline field lengths decoded from the IPHC bytes
  function automatic int inline_tf(logic [7:0] h0);
    case (h0[4:3])
      2'd0:    return 4;
      2'd1:    return 3;
      2'd2:    return 1;
      default: return 0;
    endcase
  endfunction

  function automatic int inline_src(logic [7:0] h1);
    if (h1[6:4] == 3'b000) return 16;
    case (h1[5:4])
      2'd1:    return 8;
      2'd2:    return 2;
      default: return 0;
    endcase
  endfunction

  // -1 marks a reserved destination mode
  function automatic int inline_dst(logic [7:0] h1);
    if (h1[2:0] == 3'b000) return 16;
    if (h1[3]) begin
      if (h1[2]) return (h1[1:0] == 2'd0) ? 6 : -1;
      case (h1[1:0])
        2'd1:    return 6;
        2'd2:    return 4;
        default: return 1;
      endcase
    end
    case (h1[1:0])
      2'd0:    return -1;
      2'd1:    return 8;
      2'd2:    return 2;
      default: return 0;
    endcase
  endfunction

  // NHC-UDP body bytes: inline ports plus checksum unless elided
  function automatic int nhc_body_len(logic [7:0] d);
    int n;
    case (d[1:0])
      2'd0:    n = 4;
      2'd3:    n = 1;
      default: n = 3;
    endcase
    return d[2] ? n : n + 2;
  endfunction

  function automatic void reset_prediction();
    hp_pos = '0;
    hp_skip = '0;
    hp_iphc0 = '0;
    hp_iphc1 = '0;
    hp_end = '0;
    hp_phase = PH_IDLE;
    hp_proto = '0;
    hp_nhc = '0;
    hp_sport = '0;
    hp_dport = '0;
    hp_done = 1'b0;
  endfunction

  // queue the one result word of the current frame
  function automatic void close_frame(status_t st, bit ok, bit with_ports);
    res_word_t w;
    w.status = st;
    w.header_len = ok ? hp_pos : 6'd0;
    w.next_proto = ok ? hp_proto : 8'd0;
    w.udp_sport = (ok && with_ports) ? hp_sport : 16'd0;
    w.udp_dport = (ok && with_ports) ? hp_dport : 16'd0;
    w.ports_valid = ok && with_ports;
    predicted_results.push_back(w);
    hp_phase = PH_IDLE;
    hp_done = 1'b1;
  endfunction

  function automatic void set_field_end(int n);
    hp_end = hp_pos + 6'(n);
  endfunction

  // after the addresses: NHC, plain UDP header, or done
  function automatic void plan_after_addr();
    if (hp_iphc0[2]) begin
      hp_phase = PH_NHCD;
    end else if (hp_proto == PROTO_UDP) begin
      set_field_end(8);
      hp_phase = PH_UDP;
    end else begin
      close_frame(ST_OK, 1'b1, 1'b0);
    end
  endfunction

  function automatic void plan_addr();
    int n;
    n = ((hp_iphc0[1:0] == 2'd0) ? 1 : 0) + inline_src(hp_iphc1) + inline_dst(hp_iphc1);
    if (n != 0) begin
      set_field_end(n);
      hp_phase = PH_ADDR;
    end else begin
      plan_after_addr();
    end
  endfunction

  function automatic void plan_next_header();
    if (!hp_iphc0[2]) hp_phase = PH_NHB;
    else plan_addr();
  endfunction

  function automatic void take_dispatch(logic [7:0] b, bit top);
    if (top && b[7:3] == DISP_FRAGN) begin
      close_frame(ST_LATER_FRAG, 1'b0, 1'b0);
    end else if (top && b[7:3] == DISP_FRAG1) begin
      hp_skip = FRAG_REST;
      hp_phase = PH_FRAG;
    end else if (b[7:5] == DISP_IPHC) begin
      hp_iphc0 = b;
      hp_phase = PH_IPHC2;
    end else begin
      close_frame(ST_BAD_DISPATCH, 1'b0, 1'b0);
    end
  endfunction

  // position of the current word inside a field of n bytes ending at hp_end
  function automatic int field_index(int n);
    int start;
    int cur;
    start = (hp_end >= n) ? int'(hp_end) - n : 0;
    cur = int'(hp_pos) - 1;
    return (cur >= start) ? cur - start : 0;
  endfunction

  function automatic void nhc_port_byte(logic [7:0] b);
    int idx;
    idx = field_index(nhc_body_len(hp_nhc));
    case (hp_nhc[1:0])
      2'd0: begin
        if (idx < 2) hp_sport = {hp_sport[7:0], b};
        else if (idx < 4) hp_dport = {hp_dport[7:0], b};
      end
      2'd1: begin
        if (idx < 2) hp_sport = {hp_sport[7:0], b};
        else if (idx == 2) hp_dport = NHC_PORT_8BIT | {8'd0, b};
      end
      2'd2: begin
        if (idx == 0) hp_sport = NHC_PORT_8BIT | {8'd0, b};
        else if (idx < 3) hp_dport = {hp_dport[7:0], b};
      end
      default: begin
        if (idx == 0) begin
          hp_sport = NHC_PORT_4BIT | {12'd0, b[7:4]};
          hp_dport = NHC_PORT_4BIT | {12'd0, b[3:0]};
        end
      end
    endcase
    if (hp_pos >= hp_end) close_frame(ST_OK, 1'b1, 1'b1);
  endfunction

  function automatic void udp_header_byte(logic [7:0] b);
    int idx;
    idx = field_index(8);
    if (idx < 2) hp_sport = {hp_sport[7:0], b};
    else if (idx < 4) hp_dport = {hp_dport[7:0], b};
    if (hp_pos >= hp_end) close_frame(ST_OK, 1'b1, 1'b1);
  endfunction

  // advance the predicted parser by one accepted word
  function automatic void decode_frame_byte(logic [7:0] b, bit f, bit l);
    if (f) begin
      reset_prediction();
      hp_phase = PH_DISP_TOP;
    end
    if (hp_phase != PH_IDLE) begin
      if (hp_pos < MAX_POS) hp_pos++;
      case (hp_phase)
        PH_DISP_TOP: take_dispatch(b, 1'b1);
        PH_DISP_IN:  take_dispatch(b, 1'b0);
        PH_FRAG: begin
          if (hp_skip != 0) hp_skip--;
          if (hp_skip == 0) hp_phase = PH_DISP_IN;
        end
        PH_IPHC2: begin
          hp_iphc1 = b;
          if (inline_dst(b) < 0) begin
            close_frame(ST_RSV_DST, 1'b0, 1'b0);
          end else if (hp_iphc1[7] + inline_tf(hp_iphc0) != 0) begin
            set_field_end(hp_iphc1[7] + inline_tf(hp_iphc0));
            hp_phase = PH_PRE;
          end else begin
            plan_next_header();
          end
        end
        PH_PRE: if (hp_pos >= hp_end) plan_next_header();
        PH_NHB: begin
          hp_proto = b;
          plan_addr();
        end
        PH_ADDR: if (hp_pos >= hp_end) plan_after_addr();
        PH_NHCD: begin
          if (b[7:3] != DISP_NHC_UDP) begin
            close_frame(ST_BAD_NHC, 1'b0, 1'b0);
          end else begin
            hp_nhc = b;
            hp_proto = PROTO_UDP;
            set_field_end(nhc_body_len(b));
            hp_phase = PH_NHCB;
          end
        end
        PH_NHCB: nhc_port_byte(b);
        PH_UDP:  udp_header_byte(b);
        default: hp_phase = PH_IDLE;
      endcase
      if (l && hp_phase != PH_IDLE && !hp_done) close_frame(ST_TRUNCATED, 1'b0, 1'b0);
    end
  endfunction

  // lower valid unless it is already low
  task automatic stop_offering();
    if (offering) begin
      byte_ch.valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  // offer one word, wait for the handshake, then predict
  task automatic send_byte(input logic [7:0] b, input bit f, input bit l);
    int gap;
    if (!offering) begin
      byte_ch.valid <= 1'b1;
      offering = 1'b1;
    end
    byte_ch.frame_byte <= b;
    byte_ch.first <= f;
    byte_ch.last <= l;
    do @(posedge clk); while (!byte_ch.ready);
    decode_frame_byte(b, f, l);
    bytes_sent++;
    if (sender_gaps) begin
      burst_left--;
      if (burst_left <= 0) begin
        gap = $urandom_range(1, 6);
        stop_offering();
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(1, 12);
      end
    end
  endtask

  // send frame_buf; close marks the final word as last
  task automatic send_frame(input bit close);
    for (int i = 0; i < frame_buf.size(); i++)
      send_byte(frame_buf[i], i == 0, close && i == frame_buf.size() - 1);
  endtask

  task automatic wait_drained();
    stop_offering();
    while (predicted_results.size() != 0) @(posedge clk);
  endtask

  // well-formed frame with random content, optional FRAG1 and trailing payload
  task automatic build_frame();
    logic [7:0] h0;
    logic [7:0] h1;
    logic [7:0] nd;
    logic [7:0] proto;
    frame_buf.delete();
    if ($urandom_range(0, 3) == 0) begin
      frame_buf.push_back({DISP_FRAG1, 3'($urandom)});
      repeat (3) frame_buf.push_back(8'($urandom));
    end
    h0 = {DISP_IPHC, 5'($urandom)};
    do h1 = 8'($urandom); while (inline_dst(h1) < 0 && $urandom_range(0, 4) != 0);
    frame_buf.push_back(h0);
    frame_buf.push_back(h1);
    repeat (h1[7] + inline_tf(h0)) frame_buf.push_back(8'($urandom));
    proto = 8'd0;
    if (!h0[2]) begin
      proto = ($urandom_range(0, 2) != 0) ? PROTO_UDP : 8'($urandom);
      frame_buf.push_back(proto);
    end
    if (h0[1:0] == 2'd0) frame_buf.push_back(8'($urandom));
    if (inline_dst(h1) >= 0)
      repeat (inline_src(h1) + inline_dst(h1)) frame_buf.push_back(8'($urandom));
    if (h0[2]) begin
      nd = {DISP_NHC_UDP, 3'($urandom)};
      frame_buf.push_back(nd);
      repeat (nhc_body_len(nd)) frame_buf.push_back(8'($urandom));
    end else if (proto == PROTO_UDP) begin
      repeat (8) frame_buf.push_back(8'($urandom));
    end
    repeat ($urandom_range(0, 4)) frame_buf.push_back(8'($urandom));
  endtask

  // one-word frames: dispatch extremes, later fragment, stray word, early end
  task automatic test_single_byte_frames();
    send_byte(8'h55, 1'b0, 1'b1);
    send_byte(8'hE3, 1'b1, 1'b1);
    send_byte(8'h00, 1'b1, 1'b1);
    send_byte(8'hFF, 1'b1, 1'b1);
    send_byte(8'h60, 1'b1, 1'b1);
    send_byte(8'hC1, 1'b1, 1'b1);
  endtask

  // nested fragment headers and reserved destination modes
  task automatic test_dispatch_errors();
    frame_buf = '{8'hC0, 8'h11, 8'h22, 8'h33, 8'hC7};
    send_frame(1'b1);
    frame_buf = '{8'hC4, 8'hAA, 8'hBB, 8'hCC, 8'hE5};
    send_frame(1'b1);
    frame_buf = '{8'h7B, 8'h0D};
    send_frame(1'b1);
    frame_buf = '{8'h7B, 8'h04};
    send_frame(1'b1);
  endtask

  // NHC ports, bad NHC, plain UDP, non-UDP protocol, restart mid-frame
  task automatic test_udp_paths();
    frame_buf = '{8'h7F, 8'h33, 8'hF7, 8'hAB, 8'h99};
    send_frame(1'b1);
    frame_buf = '{8'h7F, 8'h33, 8'h00};
    send_frame(1'b1);
    frame_buf = '{8'h7B, 8'h33, 8'h11, 8'h12, 8'h34, 8'h56, 8'h78, 8'h00, 8'h08,
                  8'hAB, 8'hCD, 8'h01};
    send_frame(1'b1);
    frame_buf = '{8'h7B, 8'h33, 8'h06};
    send_frame(1'b1);
    frame_buf = '{8'h7B, 8'h33};
    send_frame(1'b0);
    frame_buf = '{8'h7F, 8'h33, 8'hF4, 8'hFF, 8'hFF, 8'h00, 8'h01};
    send_frame(1'b1);
  endtask

  // receiver holds off while short frames keep coming, so the input stalls
  task automatic test_output_backpressure();
    wait_drained();
    sender_gaps = 1'b0;
    stall_style <= RX_ALWAYS;
    hold_requests <= hold_requests + 1;
    repeat (12) send_byte({DISP_FRAGN, 3'($urandom)}, 1'b1, 1'b1);
    frame_buf = '{8'h7F, 8'h33, 8'hF7, 8'h5A};
    send_frame(1'b1);
    wait_drained();
  endtask

  // mostly well-formed frames, plus truncated, corrupted, restarted and noise
  task automatic test_random_frames();
    int start_count;
    int frames;
    int pick;
    int cut;
    start_count = bytes_sent;
    frames = 0;
    while (bytes_sent - start_count < RANDOM_WORDS) begin
      if (frames % 8 == 0) begin
        stall_style <= rx_style_t'($urandom_range(0, 3));
        sender_gaps = $urandom_range(0, 3) != 0;
        if ($urandom_range(0, 5) == 0) wait_drained();
      end
      frames++;
      pick = $urandom_range(0, 99);
      build_frame();
      if (pick < 65) begin
        send_frame(1'b1);
      end else if (pick < 75) begin
        cut = $urandom_range(1, frame_buf.size());
        while (frame_buf.size() > cut) void'(frame_buf.pop_back());
        send_frame(1'b1);
      end else if (pick < 85) begin
        frame_buf[$urandom_range(0, frame_buf.size() - 1)] = 8'($urandom);
        send_frame(1'b1);
      end else if (pick < 91) begin
        cut = $urandom_range(1, frame_buf.size());
        while (frame_buf.size() > cut) void'(frame_buf.pop_back());
        send_frame(1'b0);
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, 1'($urandom));
      end else begin
        frame_buf.delete();
        repeat ($urandom_range(1, 8)) frame_buf.push_back(8'($urandom));
        send_frame(1'b1);
      end
    end
  endtask

  // receiver: long hold-off on request, otherwise the current stall style
  initial begin : receiver
    logic [15:0] pat;
    int hold_left;
    pat = 16'b1011_0011_1000_1101;
    hold_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
        res_ch.ready <= 1'b0;
      end else begin
        case (stall_style)
          RX_RANDOM:  res_ch.ready <= $urandom_range(0, 9) < 7;
          RX_PATTERN: begin
            pat = {pat[14:0], pat[15]};
            res_ch.ready <= pat[15];
          end
          RX_HEAVY:   res_ch.ready <= $urandom_range(0, 9) < 2;
          default:    res_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  // compare each accepted result word with the oldest prediction
  always @(posedge clk) begin : check_results
    res_word_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (predicted_results.size() == 0) begin
        $error("result word with no prediction: status %0d", res_ch.status);
        fail_count++;
      end else begin
        want = predicted_results.pop_front();
        if (res_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_ch.status);
          fail_count++;
        end
        if (res_ch.header_len !== want.header_len) begin
          $error("header_len: expected %0d, got %0d", want.header_len, res_ch.header_len);
          fail_count++;
        end
        if (res_ch.next_proto !== want.next_proto) begin
          $error("next_proto: expected %0d, got %0d", want.next_proto, res_ch.next_proto);
          fail_count++;
        end
        if (res_ch.udp_sport !== want.udp_sport) begin
          $error("udp_sport: expected %h, got %h", want.udp_sport, res_ch.udp_sport);
          fail_count++;
        end
        if (res_ch.udp_dport !== want.udp_dport) begin
          $error("udp_dport: expected %h, got %h", want.udp_dport, res_ch.udp_dport);
          fail_count++;
        end
        if (res_ch.ports_valid !== want.ports_valid) begin
          $error("ports_valid: expected %0d, got %0d", want.ports_valid, res_ch.ports_valid);
          fail_count++;
        end
      end
    end
  end

  // watchdog: too many cycles without any handshake ends the run
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAIL");
    $finish;
  end

  // test sequence
  initial begin
    byte_ch.valid <= 1'b0;
    byte_ch.frame_byte <= 8'd0;
    byte_ch.first <= 1'b0;
    byte_ch.last <= 1'b0;
    rst <= 1'b1;
    reset_prediction();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_single_byte_frames();
    test_dispatch_errors();
    test_udp_paths();
    test_output_backpressure();
    test_random_frames();
    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

>>> sim.f
sv/sxlp_pkg.sv
sv/sxlp_ifs.sv
sv/sixlowpan_iphc_header_parser.sv
test/sixlowpan_iphc_header_parser_tb.sv
